[design/grd_pkg.sv]
// shared types, constants and codes of the grid ray caster
package grd_pkg;

  // map and screen geometry
  localparam int MAP_SIDE     = 64;
  localparam int SCREEN_WIDTH = 640;
  localparam int MAP_W        = $clog2(MAP_SIDE);
  localparam int MAP_DEPTH    = MAP_SIDE * MAP_SIDE;
  localparam int ADDR_W       = 2 * MAP_W;

  // field widths
  localparam int CELL_W    = 6;
  localparam int COL_W     = 10;
  localparam int POS_W     = 22;
  localparam int DIR_W     = 18;
  localparam int DIST_W    = 24;
  localparam int CFG_W     = 22;
  localparam int CFG_IDX_W = 3;

  // internal widths
  localparam int MC_W     = MAP_W + 2;
  localparam int CAM_W    = 19;
  localparam int PROD_W   = DIR_W + CAM_W;
  localparam int SUM_W    = PROD_W - 16 + 1;
  localparam int DIV_N    = 40;
  localparam int DIV_D    = DIR_W;
  localparam int DD_W     = 33;
  localparam int SD_W     = 42;
  localparam int DIS_W    = POS_W + 4;
  localparam int STEP_LIMIT = 2 * MAP_SIDE + 2;
  localparam int STEP_W   = $clog2(STEP_LIMIT + 1);

  // camera coordinate: floor(column * 2^17 / SCREEN_WIDTH) by reciprocal multiply
  localparam int     CAM_SHIFT   = 20;
  localparam longint CAM_RECIP   = ((longint'(1) << (17 + CAM_SHIFT)) + SCREEN_WIDTH - 1)
                                   / SCREEN_WIDTH;
  localparam int     CAM_RECIP_W = $clog2(CAM_RECIP + 1);

  // fixed point constants
  localparam int ONE_Q16  = 65536;
  localparam int DIST_MIN = 655;
  localparam int DIST_MAX = 16777215;
  localparam int DIR_MIN  = -131072;
  localparam int DIR_MAX  = 131071;

  // front queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_CAST  = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_X   = 3'd0,
    CFG_POS_Y   = 3'd1,
    CFG_LOOK_X  = 3'd2,
    CFG_LOOK_Y  = 3'd3,
    CFG_PLANE_X = 3'd4,
    CFG_PLANE_Y = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    B_CLEAR, B_IDLE, B_CAM, B_DIR, B_SAT, B_DDX, B_DDX_W,
    B_DDY, B_DDY_W, B_SIDE, B_STEP, B_CHECK, B_WD, B_WD_W, B_FIN
  } back_state_e;

  typedef struct packed {
    op_e               op;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic              wall;
    logic [COL_W-1:0]  column;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic signed [DIR_W-1:0] look_x;
    logic signed [DIR_W-1:0] look_y;
    logic signed [DIR_W-1:0] plane_x;
    logic signed [DIR_W-1:0] plane_y;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [DIST_W-1:0] wall_dist;
    logic              side;
    logic [CELL_W-1:0] hit_x;
    logic [CELL_W-1:0] hit_y;
    logic              left;
  } res_t;

endpackage

[design/grid_raycast_dda.sv]
// top level of the grid ray caster: configuration registers, front and back ends
//
// Input words are pushed with push while full is low; each word either writes
// one map cell (cmd 0) or casts the ray of one screen column (cmd 1). A front
// queue of four words parts the input from the back end, which runs one word
// at a time. A map write yields no result. A cast walks up to 130 grid
// cells; a ray that leaves the map skips the final division. The shared
// divider serves three divisions (two delta distances, final distance),
// the camera coordinate comes from one reciprocal multiply, and each walk
// step is one map ram read. One result word is held in an output register;
// it shows while empty is low and is taken with pop. A stalled receiver holds
// the back end at its last step while the front queue keeps filling, then
// full rises. After reset the map ram is cleared one cell a cycle, all 4096
// cells, with full held high; configuration writes are taken during that pass.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i; the
// user must write it only while the block idles, which the block does not enforce.
module grid_raycast_dda (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        cmd_i,
  input  logic [5:0]  cell_x_i,
  input  logic [5:0]  cell_y_i,
  input  logic        cell_is_wall_i,
  input  logic [9:0]  column_i,
  output logic        empty,
  input  logic        pop,
  output logic [9:0]  column_out_o,
  output logic [23:0] wall_distance_o,
  output logic        hit_side_o,
  output logic [5:0]  hit_cell_x_o,
  output logic [5:0]  hit_cell_y_o,
  output logic        left_map_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [21:0] cfg_data_i
);
  import grd_pkg::*;

  cfg_t  cfg_q;
  item_t item;
  res_t  res;
  logic  item_valid, item_ready, clearing, out_valid;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_x   <= '0;
      cfg_q.pos_y   <= '0;
      cfg_q.look_x  <= DIR_W'(65536);
      cfg_q.look_y  <= '0;
      cfg_q.plane_x <= '0;
      cfg_q.plane_y <= DIR_W'(43254);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_POS_X:   cfg_q.pos_x   <= cfg_data_i;
        CFG_POS_Y:   cfg_q.pos_y   <= cfg_data_i;
        CFG_LOOK_X:  cfg_q.look_x  <= cfg_data_i[DIR_W-1:0];
        CFG_LOOK_Y:  cfg_q.look_y  <= cfg_data_i[DIR_W-1:0];
        CFG_PLANE_X: cfg_q.plane_x <= cfg_data_i[DIR_W-1:0];
        CFG_PLANE_Y: cfg_q.plane_y <= cfg_data_i[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  grd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .cmd_i          (cmd_i),
    .cell_x_i       (cell_x_i),
    .cell_y_i       (cell_y_i),
    .cell_is_wall_i (cell_is_wall_i),
    .column_i       (column_i),
    .clearing_i     (clearing),
    .item_valid_o   (item_valid),
    .item_ready_i   (item_ready),
    .item_o         (item)
  );

  grd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .clearing_o   (clearing),
    .out_pop_i    (pop),
    .out_valid_o  (out_valid),
    .res_o        (res)
  );

  // result word
  assign empty           = !out_valid;
  assign column_out_o    = res.column;
  assign wall_distance_o = res.wall_dist;
  assign hit_side_o      = res.side;
  assign hit_cell_x_o    = res.hit_x;
  assign hit_cell_y_o    = res.hit_y;
  assign left_map_o      = res.left;

  // checks
  a_dist_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> wall_distance_o >= DIST_W'(DIST_MIN))
    else $error("wall distance below clamp");

  a_left_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && left_map_o) |-> (wall_distance_o == DIST_W'(DIST_MAX) && !hit_side_o))
    else $error("left map result malformed");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> full)
    else $error("input open during map clear");

endmodule

[design/grd_ram.sv]
// generic single write, single read ram with registered read data
module grd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/grd_div.sv]
// shared restoring divider, one quotient bit per cycle
module grd_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [grd_pkg::DIV_N-1:0] dividend_i,
  input  logic [grd_pkg::DIV_D-1:0] divisor_i,
  output logic                     done_o,
  output logic [grd_pkg::DIV_N-1:0] quot_o
);
  import grd_pkg::*;

  localparam int CNT_W = $clog2(DIV_N);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_D-1:0] rem_q, rem_d;
  logic [DIV_N-1:0] quo_q, quo_d;
  logic [DIV_D-1:0] div_q, div_d;
  logic [DIV_D:0]   trial;
  logic             ge;

  // one trial subtraction per cycle
  always_comb begin
    trial  = {rem_q, quo_q[DIV_N-1]};
    ge     = trial >= {1'b0, div_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? DIV_D'(trial - {1'b0, div_q}) : DIV_D'(trial);
      quo_d = {quo_q[DIV_N-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DIV_N - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

[design/grd_front.sv]
// front end: accepts words, classifies them and queues them for the back end
module grd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  logic           cmd_i,
  input  logic [5:0]     cell_x_i,
  input  logic [5:0]     cell_y_i,
  input  logic           cell_is_wall_i,
  input  logic [9:0]     column_i,
  input  logic           clearing_i,
  output logic           item_valid_o,
  input  logic           item_ready_i,
  output grd_pkg::item_t item_o
);
  import grd_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QPTR_W:0]   cnt_q;
  logic              wr, rd;
  item_t             item_in;

  // classify the incoming word
  always_comb begin
    item_in.op     = op_e'(cmd_i);
    item_in.cell_x = cell_x_i;
    item_in.cell_y = cell_y_i;
    item_in.wall   = cell_is_wall_i;
    item_in.column = column_i;
  end

  assign full_o       = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH)) || clearing_i;
  assign wr           = push_i && !full_o;
  assign item_valid_o = cnt_q != '0;
  assign rd           = item_valid_o && item_ready_i;
  assign item_o       = mem_q[rptr_q];

  // queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr) wptr_q <= wptr_q + QPTR_W'(1);
      if (rd) rptr_q <= rptr_q + QPTR_W'(1);
      cnt_q <= cnt_q + (QPTR_W + 1)'(wr) - (QPTR_W + 1)'(rd);
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wptr_q] <= item_in;
  end

endmodule

[design/grd_back.sv]
// back end: map storage, ray setup, grid walk and distance
module grd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  grd_pkg::cfg_t  cfg_i,
  input  logic           item_valid_i,
  input  grd_pkg::item_t item_i,
  output logic           item_ready_o,
  output logic           clearing_o,
  input  logic           out_pop_i,
  output logic           out_valid_o,
  output grd_pkg::res_t  res_o
);
  import grd_pkg::*;

  back_state_e state_q, state_d;
  logic [ADDR_W-1:0] clr_q;
  logic              out_valid_q;
  res_t              res_q;

  logic [COL_W-1:0]         col_q;
  logic signed [CAM_W-1:0]  cam_q;
  logic signed [PROD_W-1:0] prodx_q, prody_q;
  logic signed [DIR_W-1:0]  dx_q, dy_q;
  logic [DD_W-1:0]          ddx_q, ddy_q;
  logic [SD_W-1:0]          sdx_q, sdy_q;
  logic signed [MC_W-1:0]   mx_q, my_q;
  logic [STEP_W-1:0]        steps_q;
  logic                     side_q, left_q, neg_q;
  logic [DIST_W-1:0]        wd_q;

  // ram and divider hookup
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic              ram_wdata, ram_rdata;
  logic              div_start, div_done;
  logic [DIV_N-1:0]  div_dividend, div_quot;
  logic [DIV_D-1:0]  div_divisor;

  function automatic logic signed [DIR_W-1:0] sat_dir(input logic signed [SUM_W-1:0] s);
    logic signed [DIR_W-1:0] r;
    if (s < SUM_W'(DIR_MIN)) r = DIR_W'(DIR_MIN);
    else if (s > SUM_W'(DIR_MAX)) r = DIR_W'(DIR_MAX);
    else r = DIR_W'(s);
    if (r == '0) r = DIR_W'(1);
    return r;
  endfunction

  function automatic logic in_map(input logic signed [MC_W-1:0] v);
    return !v[MC_W-1] && (v < MC_W'(MAP_SIDE));
  endfunction

  // direction sums, magnitudes and walk arithmetic
  logic [COL_W+CAM_RECIP_W-1:0] cam_prod;
  logic signed [SUM_W-1:0] sumx, sumy;
  logic [DIR_W-1:0]        abs_dx, abs_dy;
  logic [16:0]             fracx, fracy;
  logic [DD_W+16:0]        sprodx, sprody;
  logic                    take_x;
  logic signed [MC_W-1:0]  nmx, nmy, mx0, my0;
  logic [SD_W-1:0]         nsdx, nsdy;
  logic                    n_inside;
  logic                    cell_ok;
  logic signed [DIS_W-1:0] dis;
  logic [DIS_W-1:0]        dis_mag;

  // column times the reciprocal of the screen width
  assign cam_prod = col_q * $unsigned(CAM_RECIP_W'(CAM_RECIP));

  assign sumx = {{(SUM_W-DIR_W){cfg_i.look_x[DIR_W-1]}}, cfg_i.look_x}
              + {prodx_q[PROD_W-1], prodx_q[PROD_W-1:16]};
  assign sumy = {{(SUM_W-DIR_W){cfg_i.look_y[DIR_W-1]}}, cfg_i.look_y}
              + {prody_q[PROD_W-1], prody_q[PROD_W-1:16]};
  assign abs_dx = dx_q[DIR_W-1] ? DIR_W'(-dx_q) : DIR_W'(dx_q);
  assign abs_dy = dy_q[DIR_W-1] ? DIR_W'(-dy_q) : DIR_W'(dy_q);
  assign fracx = dx_q[DIR_W-1] ? {1'b0, cfg_i.pos_x[15:0]}
                               : 17'(17'h10000 - {1'b0, cfg_i.pos_x[15:0]});
  assign fracy = dy_q[DIR_W-1] ? {1'b0, cfg_i.pos_y[15:0]}
                               : 17'(17'h10000 - {1'b0, cfg_i.pos_y[15:0]});
  assign sprodx = fracx * ddx_q;
  assign sprody = fracy * ddy_q;
  assign mx0 = $signed(MC_W'(cfg_i.pos_x[POS_W-1:16]));
  assign my0 = $signed(MC_W'(cfg_i.pos_y[POS_W-1:16]));

  assign take_x = sdx_q < sdy_q;
  assign nmx  = !take_x ? mx_q : (dx_q[DIR_W-1] ? mx_q - MC_W'(1) : mx_q + MC_W'(1));
  assign nmy  = take_x ? my_q : (dy_q[DIR_W-1] ? my_q - MC_W'(1) : my_q + MC_W'(1));
  assign nsdx = take_x ? sdx_q + SD_W'(ddx_q) : sdx_q;
  assign nsdy = take_x ? sdy_q : sdy_q + SD_W'(ddy_q);
  assign n_inside = in_map(nmx) && in_map(nmy);

  // offset from the player to the crossed grid line
  always_comb begin
    if (!side_q) begin
      dis = {{(DIS_W-MC_W-16){mx_q[MC_W-1]}}, mx_q, 16'b0}
          - {{(DIS_W-POS_W){1'b0}}, cfg_i.pos_x}
          + (dx_q[DIR_W-1] ? DIS_W'(ONE_Q16) : DIS_W'(0));
    end else begin
      dis = {{(DIS_W-MC_W-16){my_q[MC_W-1]}}, my_q, 16'b0}
          - {{(DIS_W-POS_W){1'b0}}, cfg_i.pos_y}
          + (dy_q[DIR_W-1] ? DIS_W'(ONE_Q16) : DIS_W'(0));
    end
    dis_mag = dis[DIS_W-1] ? DIS_W'(-dis) : DIS_W'(dis);
  end

  assign cell_ok = (32'(item_i.cell_x) < 32'(MAP_SIDE)) && (32'(item_i.cell_y) < 32'(MAP_SIDE));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_CLEAR: if (clr_q == ADDR_W'(MAP_DEPTH - 1)) state_d = B_IDLE;
      B_IDLE:  if (item_valid_i && item_i.op == OP_CAST) state_d = B_CAM;
      B_CAM:   state_d = B_DIR;
      B_DIR:   state_d = B_SAT;
      B_SAT:   state_d = B_DDX;
      B_DDX:   state_d = B_DDX_W;
      B_DDX_W: if (div_done) state_d = B_DDY;
      B_DDY:   state_d = B_DDY_W;
      B_DDY_W: if (div_done) state_d = B_SIDE;
      B_SIDE:  state_d = B_STEP;
      B_STEP: begin
        if (left_q || steps_q >= STEP_W'(STEP_LIMIT) || !n_inside) state_d = B_FIN;
        else state_d = B_CHECK;
      end
      B_CHECK: state_d = ram_rdata ? B_WD : B_STEP;
      B_WD:    state_d = B_WD_W;
      B_WD_W:  if (div_done) state_d = B_FIN;
      B_FIN:   if (!out_valid_q || out_pop_i) state_d = B_IDLE;
      default: state_d = B_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item_ready_o = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = {MAP_W'(item_i.cell_y), MAP_W'(item_i.cell_x)};
    ram_wdata    = item_i.wall;
    div_start    = 1'b0;
    div_dividend = DIV_N'(64'h1_0000_0000);
    div_divisor  = abs_dx;
    case (state_q)
      B_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = 1'b0;
      end
      B_IDLE: begin
        item_ready_o = 1'b1;
        ram_we = item_valid_i && item_i.op == OP_WRITE && cell_ok;
      end
      B_DDX: div_start = 1'b1;
      B_DDY: begin
        div_start   = 1'b1;
        div_divisor = abs_dy;
      end
      B_WD: begin
        div_start    = 1'b1;
        div_dividend = DIV_N'({dis_mag, 16'b0});
        div_divisor  = side_q ? abs_dy : abs_dx;
      end
      default: ;
    endcase
  end

  assign ram_raddr = {MAP_W'(nmy), MAP_W'(nmx)};

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLEAR) clr_q <= clr_q + ADDR_W'(1);
      if (state_q == B_FIN && (!out_valid_q || out_pop_i)) out_valid_q <= 1'b1;
      else if (out_pop_i) out_valid_q <= 1'b0;
    end
  end

  // ray datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE:  col_q <= item_i.column;
      B_CAM:   cam_q <= CAM_W'(cam_prod >> CAM_SHIFT) - CAM_W'(ONE_Q16);
      B_DIR: begin
        prodx_q <= cfg_i.plane_x * cam_q;
        prody_q <= cfg_i.plane_y * cam_q;
      end
      B_SAT: begin
        dx_q <= sat_dir(sumx);
        dy_q <= sat_dir(sumy);
      end
      B_DDX_W: if (div_done) ddx_q <= DD_W'(div_quot);
      B_DDY_W: if (div_done) ddy_q <= DD_W'(div_quot);
      B_SIDE: begin
        sdx_q   <= SD_W'(sprodx >> 16);
        sdy_q   <= SD_W'(sprody >> 16);
        mx_q    <= mx0;
        my_q    <= my0;
        steps_q <= '0;
        side_q  <= 1'b0;
        left_q  <= !(in_map(mx0) && in_map(my0));
      end
      B_STEP: begin
        if (!left_q) begin
          if (steps_q >= STEP_W'(STEP_LIMIT)) begin
            left_q <= 1'b1;
          end else begin
            sdx_q   <= nsdx;
            sdy_q   <= nsdy;
            mx_q    <= nmx;
            my_q    <= nmy;
            side_q  <= !take_x;
            steps_q <= steps_q + STEP_W'(1);
            if (!n_inside) left_q <= 1'b1;
          end
        end
      end
      B_WD: neg_q <= dis[DIS_W-1] ^ (side_q ? dy_q[DIR_W-1] : dx_q[DIR_W-1]);
      B_WD_W: begin
        if (div_done) begin
          if (neg_q || div_quot < DIV_N'(DIST_MIN)) wd_q <= DIST_W'(DIST_MIN);
          else if (div_quot > DIV_N'(DIST_MAX)) wd_q <= DIST_W'(DIST_MAX);
          else wd_q <= DIST_W'(div_quot);
        end
      end
      B_FIN: begin
        if (!out_valid_q || out_pop_i) begin
          res_q.column    <= col_q;
          res_q.left      <= left_q;
          res_q.wall_dist <= left_q ? DIST_W'(DIST_MAX) : wd_q;
          res_q.side      <= left_q ? 1'b0 : side_q;
          res_q.hit_x     <= left_q ? '0 : CELL_W'(mx_q);
          res_q.hit_y     <= left_q ? '0 : CELL_W'(my_q);
        end
      end
      default: ;
    endcase
  end

  grd_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  grd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign clearing_o  = state_q == B_CLEAR;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule
